// ===== design/lbr_pkg.sv =====
// shared types, constants and color scaling for the lamp brightness regulator
`timescale 1ns / 1ps
package lbr_pkg;

   localparam int LEVEL_W  = 14;
   localparam int AMOUNT_W = 16;
   localparam int COLOUR_W = 8;

   localparam logic [LEVEL_W-1:0]  LEVEL_MAX      = 14'd10000;
   localparam logic [LEVEL_W-1:0]  LEVEL_DEFAULT  = 14'd5000;
   localparam logic [AMOUNT_W-1:0] TARGET_DEFAULT = 16'd350;

   // auto mode loop gain per lux of error
   localparam int GAIN = 5;

   // floor(base * level / 10000) as level * ceil(base * 2^27 / 10000) >> 27,
   // exact for every level up to 10000
   localparam int SCALE_SHIFT = 27;
   localparam int MULT_W      = 22;
   localparam longint unsigned SCALE_DEN = 10000;
   localparam longint unsigned MULT_FULL_L =
      ((longint'(255) << SCALE_SHIFT) + SCALE_DEN - 1) / SCALE_DEN;
   localparam longint unsigned MULT_WARM_G_L =
      ((longint'(180) << SCALE_SHIFT) + SCALE_DEN - 1) / SCALE_DEN;
   localparam longint unsigned MULT_WARM_B_L =
      ((longint'(80) << SCALE_SHIFT) + SCALE_DEN - 1) / SCALE_DEN;
   localparam logic [MULT_W-1:0] MULT_FULL   = MULT_W'(MULT_FULL_L);
   localparam logic [MULT_W-1:0] MULT_WARM_G = MULT_W'(MULT_WARM_G_L);
   localparam logic [MULT_W-1:0] MULT_WARM_B = MULT_W'(MULT_WARM_B_L);

   typedef enum logic [1:0] {
      CMD_SET_LEVEL = 2'd0,
      CMD_SWITCH    = 2'd1,
      CMD_SET_AUTO  = 2'd2,
      CMD_SAMPLE    = 2'd3
   } command_type;

   typedef struct packed {
      command_type         command;
      logic [AMOUNT_W-1:0] amount;
      logic                flag;
   } item_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               lit;
   } emit_type;

   // one color channel scaled by the level
   function automatic logic [COLOUR_W-1:0] scale_channel(
      input logic [LEVEL_W-1:0] level,
      input logic [MULT_W-1:0]  mult
   );
      logic [LEVEL_W+MULT_W-1:0] prod;
      prod = (LEVEL_W+MULT_W)'(level) * (LEVEL_W+MULT_W)'(mult);
      return prod[SCALE_SHIFT +: COLOUR_W];
   endfunction

endpackage

// ===== design/lbr_state.sv =====
// lamp state registers and the per-command update
`timescale 1ns / 1ps
module lbr_state
   import lbr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     go,
   input  item_type item,
   output logic     result_valid,
   output emit_type result
);

   logic [LEVEL_W-1:0]  level_now_ff, level_now_in;
   logic [LEVEL_W-1:0]  level_saved_ff, level_saved_in;
   logic                enabled_ff, enabled_in;
   logic                auto_on_ff, auto_on_in;
   logic [AMOUNT_W-1:0] target_ff, target_in;
   logic                produce;
   logic [LEVEL_W-1:0]  set_level;
   logic signed [AMOUNT_W:0] lux_error;
   logic signed [19:0]  step_sum;
   logic [LEVEL_W-1:0]  step_level;

   // saturated manual level
   assign set_level = (item.amount > AMOUNT_W'(LEVEL_MAX)) ? LEVEL_MAX
                                                          : item.amount[LEVEL_W-1:0];

   // auto step: level + gain * (target - measured), clamped to 0..max
   always_comb begin
      lux_error = $signed({1'b0, target_ff}) - $signed({1'b0, item.amount});
      step_sum  = $signed(20'({1'b0, level_now_ff}))
                + 20'(lux_error) * 20'(GAIN);
      if (step_sum < 20'sd0) begin
         step_level = '0;
      end else if (step_sum > $signed(20'({1'b0, LEVEL_MAX}))) begin
         step_level = LEVEL_MAX;
      end else begin
         step_level = step_sum[LEVEL_W-1:0];
      end
   end

   // next state per command
   always_comb begin
      level_now_in   = level_now_ff;
      level_saved_in = level_saved_ff;
      enabled_in     = enabled_ff;
      auto_on_in     = auto_on_ff;
      target_in      = target_ff;
      produce        = 1'b0;
      unique case (item.command)
         CMD_SET_LEVEL: begin
            auto_on_in   = 1'b0;
            level_now_in = set_level;
            enabled_in   = (set_level != '0);
            if (set_level != '0) begin
               level_saved_in = set_level;
            end
            produce = 1'b1;
         end
         CMD_SWITCH: begin
            if (item.flag) begin
               enabled_in = 1'b1;
               if (level_now_ff == '0) begin
                  if (level_saved_ff == '0) begin
                     level_saved_in = LEVEL_DEFAULT;
                     level_now_in   = LEVEL_DEFAULT;
                  end else begin
                     level_now_in = level_saved_ff;
                  end
               end
            end else begin
               enabled_in = 1'b0;
               if (level_now_ff != '0) begin
                  level_saved_in = level_now_ff;
               end
               level_now_in = '0;
            end
            auto_on_in = 1'b0;
            produce    = 1'b1;
         end
         CMD_SET_AUTO: begin
            auto_on_in = item.flag;
            if (item.flag && item.amount != '0) begin
               target_in = item.amount;
            end
         end
         CMD_SAMPLE: begin
            if (auto_on_ff && enabled_ff) begin
               level_now_in = step_level;
               if (step_level != '0) begin
                  level_saved_in = step_level;
               end
               produce = 1'b1;
            end
         end
         default: begin
            produce = 1'b0;
         end
      endcase
   end

   assign result_valid = go && produce;
   assign result.level = level_now_in;
   assign result.lit   = enabled_in && (level_now_in != '0);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         level_now_ff   <= LEVEL_DEFAULT;
         level_saved_ff <= LEVEL_DEFAULT;
         enabled_ff     <= 1'b1;
         auto_on_ff     <= 1'b1;
         target_ff      <= TARGET_DEFAULT;
      end else if (go) begin
         level_now_ff   <= level_now_in;
         level_saved_ff <= level_saved_in;
         enabled_ff     <= enabled_in;
         auto_on_ff     <= auto_on_in;
         target_ff      <= target_in;
      end
   end

   // level stays in range
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_now_ff <= LEVEL_MAX)
      else $error("level above maximum");

   // a disabled lamp holds a zero level
   a_disabled_dark: assert property (@(posedge clock) disable iff (reset)
      !enabled_ff |-> level_now_ff == '0)
      else $error("disabled lamp with nonzero level");

   // the saved level is never zero
   a_saved_nonzero: assert property (@(posedge clock) disable iff (reset)
      level_saved_ff != '0)
      else $error("saved level is zero");

endmodule

// ===== design/lamp_brightness_regulator.sv =====
// top level of the lamp brightness regulator
`timescale 1ns / 1ps
// Takes one request per cycle while req_stall is low: a request is
// registered, the lamp state is updated from it into the emit register,
// and the drive color is scaled by a constant multiply on the way into
// the result register. The single state-update stage is the loop that
// sets the rate; it needs no bubble, so requests may follow
// back to back. Set-auto requests and lux samples outside auto mode (or while
// the lamp is off) leave no result. The color select register may be
// written only while no request is in flight; csr_ready is always high.
module lamp_brightness_regulator
   import lbr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_command,
   input  logic [AMOUNT_W-1:0] req_amount,
   input  logic                req_flag,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [COLOUR_W-1:0] rsp_red,
   output logic [COLOUR_W-1:0] rsp_green,
   output logic [COLOUR_W-1:0] rsp_blue,
   output logic [LEVEL_W-1:0]  rsp_level,
   output logic                rsp_lit,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_warm_colour
);

   logic     req_accept;
   logic     s1_valid_ff, s1_valid_in, s1_go;
   item_type item_ff;
   logic     s2_valid_ff, s2_valid_in, s2_free;
   emit_type emit_ff;
   logic     s3_load;
   logic     rsp_valid_ff, rsp_valid_in;
   logic [COLOUR_W-1:0] red_ff, green_ff, blue_ff;
   logic [COLOUR_W-1:0] red_in, green_in, blue_in;
   logic [LEVEL_W-1:0]  level_ff;
   logic                lit_ff;
   logic                warm_ff;
   logic                state_valid;
   emit_type            state_result;
   logic [MULT_W-1:0]   mult_green, mult_blue;

   // pipeline flow
   assign s3_load     = !rsp_valid_ff || !rsp_stall;
   assign s2_free     = !s2_valid_ff || s3_load;
   assign s1_go       = s1_valid_ff && s2_free;
   assign req_stall   = s1_valid_ff && !s2_free;
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_go);
   assign s2_valid_in = s2_free ? state_valid : 1'b1;
   assign rsp_valid_in = s3_load ? s2_valid_ff : 1'b1;

   lbr_state u_state (
      .clock        (clock),
      .reset        (reset),
      .go           (s1_go),
      .item         (item_ff),
      .result_valid (state_valid),
      .result       (state_result)
   );

   // color scaling from the level
   always_comb begin
      mult_green = warm_ff ? MULT_WARM_G : MULT_FULL;
      mult_blue  = warm_ff ? MULT_WARM_B : MULT_FULL;
      if (emit_ff.lit) begin
         red_in   = scale_channel(emit_ff.level, MULT_FULL);
         green_in = scale_channel(emit_ff.level, mult_green);
         blue_in  = scale_channel(emit_ff.level, mult_blue);
      end else begin
         red_in   = '0;
         green_in = '0;
         blue_in  = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         warm_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            warm_ff <= csr_warm_colour;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.command <= command_type'(req_command);
         item_ff.amount  <= req_amount;
         item_ff.flag    <= req_flag;
      end
      if (s2_free && state_valid) begin
         emit_ff <= state_result;
      end
      if (s3_load && s2_valid_ff) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         level_ff <= emit_ff.level;
         lit_ff   <= emit_ff.lit;
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;
   assign rsp_level = level_ff;
   assign rsp_lit   = lit_ff;

   // a lit result carries a nonzero level
   a_lit_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lit |-> rsp_level != '0)
      else $error("lit result with zero level");

   // a dark result is black
   a_dark_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_lit |-> rsp_red == '0 && rsp_green == '0 && rsp_blue == '0)
      else $error("dark result with nonzero color");

   // stalling the request side needs both later stages full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s2_valid_ff && rsp_valid_ff)
      else $error("request stalled with room in the pipeline");

endmodule

// ===== tb/tb_lamp_brightness_regulator.sv =====
// self-checking testbench for the lamp brightness regulator
`timescale 1ns / 1ps
module tb_lamp_brightness_regulator;
   import lbr_pkg::*;

   localparam int SETTLE_CYCLES = 8;     // pipeline is three deep, margin on top
   localparam int PHASE_ITEMS   = 250;
   localparam int PHASES        = 5;
   localparam int LONG_HOLD     = 200;

   // one drive color result
   typedef struct packed {
      logic [COLOUR_W-1:0] red;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] blue;
      logic [LEVEL_W-1:0]  level;
      logic                lit;
   } drive_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   // one line of the directed plan; flag carries the color select on csr rows
   typedef struct packed {
      row_kind_type        kind;
      command_type         command;
      logic [AMOUNT_W-1:0] amount;
      logic                flag;
      logic                typed;
      drive_type           want;
   } plan_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid;
   logic                req_stall;
   logic [1:0]          req_command;
   logic [AMOUNT_W-1:0] req_amount;
   logic                req_flag;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [COLOUR_W-1:0] rsp_red;
   logic [COLOUR_W-1:0] rsp_green;
   logic [COLOUR_W-1:0] rsp_blue;
   logic [LEVEL_W-1:0]  rsp_level;
   logic                rsp_lit;
   logic                csr_valid;
   logic                csr_ready;
   logic                csr_warm_colour;

   // expectation carried along with the request payload for typed rows
   logic      row_typed;
   drive_type row_want;

   // predicted lamp state
   logic [LEVEL_W-1:0]  lvl_now;
   logic [LEVEL_W-1:0]  lvl_saved;
   logic                lamp_on;
   logic                auto_pred;
   logic [AMOUNT_W-1:0] target_pred;
   logic                warm_sel;

   drive_type colour_due [$];

   int fault_cnt     = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int auto_steps    = 0;
   bit no_idle       = 1'b0;
   bit long_hold_ask = 1'b0;

   plan_row_type plan [29];

   lamp_brightness_regulator u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_amount      (req_amount),
      .req_flag        (req_flag),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_level       (rsp_level),
      .rsp_lit         (rsp_lit),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_warm_colour (csr_warm_colour)
   );

   always #2 clock = ~clock;

   // run limit, several times the slowest legal run
   initial begin : watchdog
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // base color scaled by the current level, black when not lit
   function automatic drive_type drive_now();
      int unsigned r;
      int unsigned g;
      int unsigned b;
      drive_type d;
      r = 255;
      g = warm_sel ? 180 : 255;
      b = warm_sel ? 80 : 255;
      d.lit = lamp_on && (lvl_now != 0);
      if (d.lit) begin
         r = r * lvl_now / LEVEL_MAX;
         g = g * lvl_now / LEVEL_MAX;
         b = b * lvl_now / LEVEL_MAX;
      end else begin
         r = 0;
         g = 0;
         b = 0;
      end
      d.red   = r[COLOUR_W-1:0];
      d.green = g[COLOUR_W-1:0];
      d.blue  = b[COLOUR_W-1:0];
      d.level = lvl_now;
      return d;
   endfunction

   // lamp state update for one request; emits tells whether a color follows
   task automatic lamp_update(input command_type cmd, input logic [AMOUNT_W-1:0] amt,
                              input logic flg, output bit emits);
      int nv;
      emits = 1'b0;
      case (cmd)
         CMD_SET_LEVEL: begin
            lvl_now = (amt > LEVEL_MAX) ? LEVEL_MAX : amt[LEVEL_W-1:0];
            if (lvl_now != 0) lvl_saved = lvl_now;
            lamp_on   = (lvl_now != 0);
            auto_pred = 1'b0;
            emits     = 1'b1;
         end
         CMD_SWITCH: begin
            if (flg) begin
               lamp_on = 1'b1;
               if (lvl_now == 0) begin
                  if (lvl_saved == 0) lvl_saved = LEVEL_DEFAULT;
                  lvl_now = lvl_saved;
               end
            end else begin
               lamp_on = 1'b0;
               if (lvl_now != 0) lvl_saved = lvl_now;
               lvl_now = '0;
            end
            auto_pred = 1'b0;
            emits     = 1'b1;
         end
         CMD_SET_AUTO: begin
            auto_pred = flg;
            if (flg && amt != 0) target_pred = amt;
         end
         default: begin
            // lux sample: only moves the level in auto mode with the lamp enabled
            if (auto_pred && lamp_on) begin
               nv = int'(lvl_now) + GAIN * (int'(target_pred) - int'(amt));
               if (nv < 0) nv = 0;
               if (nv > int'(LEVEL_MAX)) nv = int'(LEVEL_MAX);
               lvl_now = nv[LEVEL_W-1:0];
               if (lvl_now != 0) lvl_saved = lvl_now;
               emits = 1'b1;
            end
         end
      endcase
   endtask

   // follow requests, config writes and results at every rising edge
   always @(posedge clock) begin : lamp_watch
      bit        emits;
      drive_type got;
      drive_type want;
      if (reset) begin
         lvl_now     = LEVEL_DEFAULT;
         lvl_saved   = LEVEL_DEFAULT;
         lamp_on     = 1'b1;
         auto_pred   = 1'b1;
         target_pred = TARGET_DEFAULT;
         warm_sel    = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_red, rsp_green, rsp_blue, rsp_level, rsp_lit};
            results_seen++;
            if (colour_due.size() == 0) begin
               fault_cnt++;
               if (fault_cnt <= 10)
                  $display("unexpected result rgb=%0d,%0d,%0d level=%0d lit=%0d",
                           got.red, got.green, got.blue, got.level, got.lit);
            end else begin
               want = colour_due.pop_front();
               if (got.red !== want.red || got.green !== want.green ||
                   got.blue !== want.blue || got.level !== want.level ||
                   got.lit !== want.lit) begin
                  fault_cnt++;
                  if (fault_cnt <= 10)
                     $display("mismatch: want rgb=%0d,%0d,%0d level=%0d lit=%0d,",
                              want.red, want.green, want.blue, want.level, want.lit,
                              " got rgb=%0d,%0d,%0d level=%0d lit=%0d",
                              got.red, got.green, got.blue, got.level, got.lit);
               end
            end
         end
         if (csr_valid && csr_ready) warm_sel = csr_warm_colour;
         if (req_valid && !req_stall) begin
            items_sent++;
            lamp_update(command_type'(req_command), req_amount, req_flag, emits);
            if (emits) begin
               if (command_type'(req_command) == CMD_SAMPLE) auto_steps++;
               colour_due.push_back(row_typed ? row_want : drive_now());
            end
         end
      end
   end

   // idle length: mostly none, some short, a few long
   function automatic int unsigned gap_len();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (no_idle || p < 55) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // result side stall pattern, with a long hold-off on demand
   initial begin : rsp_side
      int unsigned stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_ask) begin
            long_hold_ask = 1'b0;
            stall_left    = LONG_HOLD;
         end else if (stall_left == 0 && $urandom_range(0, 2) == 0) begin
            stall_left = gap_len();
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // offer one request and hold it until accepted, then idle a while
   task automatic send_req(input command_type cmd, input logic [AMOUNT_W-1:0] amt,
                           input logic flg, input logic typed, input drive_type want);
      int unsigned g;
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_amount  <= amt;
      req_flag    <= flg;
      row_typed   <= typed;
      row_want    <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
   endtask

   // stop offering and let every outstanding result come out
   task automatic settle();
      req_valid <= 1'b0;
      while (colour_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_warm(input logic v);
      csr_valid       <= 1'b1;
      csr_warm_colour <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // random request, steered back into auto mode most of the time
   task automatic random_req(output command_type cmd, output logic [AMOUNT_W-1:0] amt,
                             output logic flg);
      int unsigned p;
      int          lux;
      p   = $urandom_range(0, 99);
      flg = 1'($urandom_range(0, 1));
      amt = AMOUNT_W'($urandom);
      if ((!auto_pred || !lamp_on) && $urandom_range(0, 3) != 0) begin
         if (!lamp_on) begin
            cmd = CMD_SWITCH;
            flg = 1'b1;
         end else begin
            cmd = CMD_SET_AUTO;
            flg = 1'b1;
            if ($urandom_range(0, 2) != 0) amt = AMOUNT_W'($urandom_range(0, 2000));
         end
      end else if (p < 8) begin
         cmd = CMD_SET_LEVEL;
         p   = $urandom_range(0, 9);
         if (p < 7) amt = AMOUNT_W'($urandom_range(0, 10000));
         else if (p == 7) amt = '0;
      end else if (p < 16) begin
         cmd = CMD_SWITCH;
      end else if (p < 24) begin
         cmd = CMD_SET_AUTO;
         flg = ($urandom_range(0, 99) < 85);
         p   = $urandom_range(0, 9);
         if (p < 6) amt = AMOUNT_W'($urandom_range(0, 2000));
         else if (p == 6) amt = '0;
      end else begin
         cmd = CMD_SAMPLE;
         if ($urandom_range(0, 3) != 0) begin
            lux = int'(target_pred) + int'($urandom_range(0, 400)) - 200;
            if (lux < 0) lux = 0;
            if (lux > 65535) lux = 65535;
            amt = lux[AMOUNT_W-1:0];
         end
      end
   endtask

   initial begin : stimulus
      command_type         cmd;
      logic [AMOUNT_W-1:0] amt;
      logic                flg;
      int                  counted;
      int                  warm_phases;

      req_valid       = 1'b0;
      req_command     = CMD_SET_LEVEL;
      req_amount      = '0;
      req_flag        = 1'b0;
      row_typed       = 1'b0;
      row_want        = '0;
      csr_valid       = 1'b0;
      csr_warm_colour = 1'b0;
      warm_phases     = 0;

      // directed plan, starting from the reset state
      plan = '{
         // sample at target leaves the reset level
         '{ROW_REQ, CMD_SAMPLE,    16'd350,   1'b0, 1'b1, '{8'd127, 8'd127, 8'd127, 14'd5000, 1'b1}},
         '{ROW_REQ, CMD_SAMPLE,    16'd0,     1'b1, 1'b0, '0},
         // sample driving the level to zero while still enabled
         '{ROW_REQ, CMD_SAMPLE,    16'hFFFF,  1'b0, 1'b1, '{8'd0, 8'd0, 8'd0, 14'd0, 1'b0}},
         '{ROW_REQ, CMD_SAMPLE,    16'd0,     1'b0, 1'b0, '0},
         // auto on with zero target keeps the old target
         '{ROW_REQ, CMD_SET_AUTO,  16'd0,     1'b1, 1'b0, '0},
         '{ROW_REQ, CMD_SET_AUTO,  16'hFFFF,  1'b1, 1'b0, '0},
         '{ROW_REQ, CMD_SAMPLE,    16'd0,     1'b0, 1'b1, '{8'd255, 8'd255, 8'd255, 14'd10000, 1'b1}},
         '{ROW_REQ, CMD_SET_AUTO,  16'd1000,  1'b0, 1'b0, '0},
         // sample outside auto mode is dropped
         '{ROW_REQ, CMD_SAMPLE,    16'd100,   1'b1, 1'b0, '0},
         '{ROW_REQ, CMD_SET_LEVEL, 16'hFFFF,  1'b1, 1'b1, '{8'd255, 8'd255, 8'd255, 14'd10000, 1'b1}},
         '{ROW_REQ, CMD_SET_LEVEL, 16'd0,     1'b0, 1'b1, '{8'd0, 8'd0, 8'd0, 14'd0, 1'b0}},
         '{ROW_REQ, CMD_SWITCH,    16'd0,     1'b1, 1'b1, '{8'd255, 8'd255, 8'd255, 14'd10000, 1'b1}},
         '{ROW_REQ, CMD_SET_LEVEL, 16'd1,     1'b0, 1'b1, '{8'd0, 8'd0, 8'd0, 14'd1, 1'b1}},
         '{ROW_REQ, CMD_SWITCH,    16'hFFFF,  1'b0, 1'b1, '{8'd0, 8'd0, 8'd0, 14'd0, 1'b0}},
         '{ROW_REQ, CMD_SWITCH,    16'd0,     1'b0, 1'b1, '{8'd0, 8'd0, 8'd0, 14'd0, 1'b0}},
         '{ROW_REQ, CMD_SAMPLE,    16'd0,     1'b0, 1'b0, '0},
         '{ROW_REQ, CMD_SWITCH,    16'hFFFF,  1'b1, 1'b0, '0},
         '{ROW_REQ, CMD_SWITCH,    16'd0,     1'b1, 1'b0, '0},
         '{ROW_REQ, CMD_SET_LEVEL, 16'd10000, 1'b1, 1'b1, '{8'd255, 8'd255, 8'd255, 14'd10000, 1'b1}},
         // warm base color
         '{ROW_CSR, CMD_SET_LEVEL, 16'd0,     1'b1, 1'b0, '0},
         '{ROW_REQ, CMD_SET_LEVEL, 16'd10000, 1'b0, 1'b1, '{8'd255, 8'd180, 8'd80, 14'd10000, 1'b1}},
         '{ROW_REQ, CMD_SET_LEVEL, 16'd9999,  1'b0, 1'b1, '{8'd254, 8'd179, 8'd79, 14'd9999, 1'b1}},
         '{ROW_REQ, CMD_SET_AUTO,  16'd350,   1'b1, 1'b0, '0},
         '{ROW_REQ, CMD_SAMPLE,    16'd349,   1'b1, 1'b0, '0},
         '{ROW_REQ, CMD_SAMPLE,    16'd1350,  1'b0, 1'b0, '0},
         '{ROW_REQ, CMD_SET_LEVEL, 16'd0,     1'b1, 1'b1, '{8'd0, 8'd0, 8'd0, 14'd0, 1'b0}},
         // auto on while disabled: the sample is dropped
         '{ROW_REQ, CMD_SET_AUTO,  16'd0,     1'b1, 1'b0, '0},
         '{ROW_REQ, CMD_SAMPLE,    16'd0,     1'b1, 1'b0, '0},
         '{ROW_CSR, CMD_SET_LEVEL, 16'd0,     1'b0, 1'b0, '0}
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed plan
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            settle();
            write_warm(plan[i].flag);
         end else begin
            send_req(plan[i].command, plan[i].amount, plan[i].flag,
                     plan[i].typed, plan[i].want);
         end
      end

      // random phases, each under its own color select
      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         flg = (ph == 0) ? 1'b1 : (ph == 1) ? 1'b0 : 1'($urandom_range(0, 1));
         if (flg) warm_phases++;
         write_warm(flg);
         no_idle = (ph == 2);
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            // long output hold-off while requests keep coming
            if (ph == 1 && counted == 60) long_hold_ask = 1'b1;
            // pause the input until the pipeline has emptied
            if (ph == 3 && counted == 120) begin
               req_valid <= 1'b0;
               while (colour_due.size() != 0) @(negedge clock);
               @(negedge clock);
            end
            random_req(cmd, amt, flg);
            if (cmd != CMD_SAMPLE || (auto_pred && lamp_on)) counted++;
            send_req(cmd, amt, flg, 1'b0, '0);
         end
      end
      no_idle = 1'b0;

      settle();
      repeat (20) @(negedge clock);
      if (colour_due.size() != 0) fault_cnt++;

      $display("covered %0d requests, %0d color results, %0d applied lux samples",
               items_sent, results_seen, auto_steps);
      $display("both base colors (%0d warm random phases), long output hold-off, input pause",
               warm_phases);
      if (fault_cnt == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d failures", fault_cnt);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
